// ===== hdl/session_table_with_aging_top_macros.svh =====
// Assertion macros for the session table top level.
// Depends on nothing; the including module supplies clk and arst_n.
`ifndef SESSION_TABLE_WITH_AGING_TOP_MACROS_SVH
`define SESSION_TABLE_WITH_AGING_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define STA_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error("session table assertion failed");
`define STA_ASSERT_NEXT(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
	else $error("session table assertion failed");
`else
`define STA_ASSERT(label, prop)
`define STA_ASSERT_NEXT(label, pre, post)
`endif
`endif

// ===== hdl/sta_pkg.sv =====
// Package for the session table: sizes, command and status codes, item types.
// No dependencies.
`timescale 1ns / 1ps
package sta_pkg;
	localparam int MAX_ENTRIES = 16;
	localparam int ID_BYTES = 8;
	localparam int IDX_W = $clog2(MAX_ENTRIES);
	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
	localparam logic [63:0] ID_MASK = (ID_BYTES >= 8) ? {64{1'b1}} :
		((64'd1 << (8 * ID_BYTES)) - 64'd1);

	localparam logic [2:0] CMD_ADD    = 3'd0;
	localparam logic [2:0] CMD_TOUCH  = 3'd1;
	localparam logic [2:0] CMD_REMOVE = 3'd2;
	localparam logic [2:0] CMD_SWEEP  = 3'd3;
	localparam logic [2:0] CMD_FIND   = 3'd4;

	localparam logic [2:0] ST_DONE     = 3'd0;
	localparam logic [2:0] ST_PRESENT  = 3'd1;
	localparam logic [2:0] ST_FULL     = 3'd2;
	localparam logic [2:0] ST_NOTFOUND = 3'd3;
	localparam logic [2:0] ST_EXPIRED  = 3'd4;

	typedef struct packed {
		logic [2:0]  command;
		logic [63:0] sess_id;
		logic [31:0] ip_addr;
		logic [15:0] port;
		logic [31:0] now;
	} req_item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [3:0]  slot;
		logic [63:0] sess_id_out;
		logic [31:0] ip_out;
		logic [15:0] port_out;
		logic [4:0]  held_count;
		logic [31:0] added_total;
		logic [4:0]  expired_count;
		logic        last;
	} rsp_item_t;
endpackage

// ===== hdl/sta_if.sv =====
// Valid/ready channel interfaces for commands and results.
// Depends on sta_pkg.
`timescale 1ns / 1ps
interface sta_req_if;
	sta_pkg::req_item_t data;
	logic valid;
	logic ready;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface sta_rsp_if;
	sta_pkg::rsp_item_t data;
	logic valid;
	logic ready;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/session_table_with_aging_top.sv =====
// Session table top level: storage, sequencer and result register.
// Depends on sta_pkg, sta_if.sv and session_table_with_aging_top_macros.svh.
`timescale 1ns / 1ps
`include "session_table_with_aging_top_macros.svh"
// One command at a time. A sequencer walks the sixteen-entry table one slot per cycle
// through a single read port and a single compare unit. Add, touch, remove and find
// scan the held entries up to the first hit; a full table on add or an unknown command
// goes straight to the result. A remove then closes the gap by moving each later entry
// down one slot. A sweep makes a marking pass, a reporting pass from the top slot down
// and a packing pass. Results leave through an output register; while a result is not
// taken, the walk pauses at the next result. A new command is accepted only in the idle
// state.
module session_table_with_aging_top (
	input  logic clk,
	input  logic arst_n,
	sta_req_if.sink req,
	sta_rsp_if.source rsp,
	input  logic cfg_we,
	input  logic [15:0] cfg_data
);
	import sta_pkg::*;

	localparam logic [2:0] S_IDLE    = 3'd0;
	localparam logic [2:0] S_SCAN    = 3'd1;
	localparam logic [2:0] S_MARK    = 3'd2;
	localparam logic [2:0] S_REPORT  = 3'd3;
	localparam logic [2:0] S_COMPACT = 3'd4;
	localparam logic [2:0] S_RESP    = 3'd5;
	localparam logic [2:0] S_SHIFT   = 3'd6;

	logic [63:0] id_mem [MAX_ENTRIES];
	logic [31:0] ip_mem [MAX_ENTRIES];
	logic [15:0] port_mem [MAX_ENTRIES];
	logic [31:0] la_mem [MAX_ENTRIES];

	logic [2:0] state_q;
	logic [CNT_W-1:0] count_q, n_q, i_q, w_q, exp_q;
	logic [31:0] total_q;
	logic [15:0] timeout_q;
	logic [MAX_ENTRIES-1:0] flag_q;
	logic [2:0] cmd_q;
	logic [63:0] id_q;
	logic [31:0] ip_q, now_q;
	logic [15:0] port_q;
	logic [2:0] res_st_q;
	logic [IDX_W-1:0] res_slot_q;
	logic res_has_q, res_shift_q;
	logic [CNT_W-1:0] res_exp_q;
	logic out_v_q;
	rsp_item_t out_q;

	logic [IDX_W-1:0] rd_idx, wa;
	logic [63:0] rid;
	logic [31:0] rip, rla, idle;
	logic [15:0] rport;
	logic match, exp_hit, out_free, out_load, we_all, we_la;
	logic [CNT_W-1:0] i_dec, i_inc;
	logic [63:0] w_id;
	logic [31:0] w_ip, w_la;
	logic [15:0] w_port;

	assign out_free = !out_v_q || rsp.ready;
	assign req.ready = (state_q == S_IDLE);
	assign rsp.valid = out_v_q;
	assign rsp.data = out_q;
	assign i_dec = i_q - 1'b1;
	assign i_inc = i_q + 1'b1;

	// Load the output register with a final result or an expiry report
	assign out_load = out_free && ((state_q == S_RESP) ||
		(state_q == S_REPORT && i_q != '0 && flag_q[i_dec[IDX_W-1:0]]));

	// Select the read slot for the current step
	always_comb begin
		case (state_q)
			S_REPORT: rd_idx = i_dec[IDX_W-1:0];
			S_RESP:   rd_idx = res_slot_q;
			S_SHIFT:  rd_idx = i_inc[IDX_W-1:0];
			default:  rd_idx = i_q[IDX_W-1:0];
		endcase
	end

	assign rid = id_mem[rd_idx];
	assign rip = ip_mem[rd_idx];
	assign rport = port_mem[rd_idx];
	assign rla = la_mem[rd_idx];

	// Shared compare unit
	assign match = (cmd_q == CMD_FIND) ? (rip == ip_q && rport == port_q)
		: ((rid & ID_MASK) == id_q);
	assign idle = now_q - rla;
	assign exp_hit = !idle[31] && (idle >= {16'd0, timeout_q});

	// Table write port
	always_comb begin
		we_all = 1'b0;
		we_la = 1'b0;
		wa = i_q[IDX_W-1:0];
		w_id = rid;
		w_ip = rip;
		w_port = rport;
		w_la = rla;
		case (state_q)
			S_SCAN: begin
				if (i_q == count_q && cmd_q == CMD_ADD) begin
					we_all = 1'b1;
					wa = count_q[IDX_W-1:0];
					w_id = id_q;
					w_ip = ip_q;
					w_port = port_q;
					w_la = now_q;
				end else if (i_q < count_q && match && cmd_q == CMD_TOUCH) begin
					we_la = 1'b1;
					w_la = now_q;
				end
			end
			S_COMPACT: begin
				if (i_q < n_q && !flag_q[i_q[IDX_W-1:0]]) begin
					we_all = 1'b1;
					wa = w_q[IDX_W-1:0];
				end
			end
			S_SHIFT: begin
				if (i_inc < n_q) begin
					we_all = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we_all) begin
			id_mem[wa] <= w_id;
			ip_mem[wa] <= w_ip;
			port_mem[wa] <= w_port;
		end
		if (we_all || we_la) begin
			la_mem[wa] <= w_la;
		end
	end

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= 16'd30;
		end else if (cfg_we) begin
			timeout_q <= cfg_data;
		end
	end

	// Sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			total_q <= '0;
			out_v_q <= 1'b0;
			i_q <= '0;
			n_q <= '0;
			w_q <= '0;
			exp_q <= '0;
			flag_q <= '0;
			res_shift_q <= 1'b0;
		end else begin
			// Hold a waiting result, drop it once taken
			if (out_load) begin
				out_v_q <= 1'b1;
			end else if (out_free) begin
				out_v_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						cmd_q <= req.data.command;
						id_q <= req.data.sess_id & ID_MASK;
						ip_q <= req.data.ip_addr;
						port_q <= req.data.port;
						now_q <= req.data.now;
						i_q <= '0;
						res_has_q <= 1'b0;
						res_slot_q <= '0;
						res_exp_q <= '0;
						res_shift_q <= 1'b0;
						if (req.data.command == CMD_ADD && count_q >= CNT_W'(MAX_ENTRIES)) begin
							res_st_q <= ST_FULL;
							state_q <= S_RESP;
						end else if (req.data.command == CMD_SWEEP) begin
							exp_q <= '0;
							flag_q <= '0;
							state_q <= S_MARK;
						end else if (req.data.command <= CMD_FIND) begin
							state_q <= S_SCAN;
						end else begin
							res_st_q <= ST_NOTFOUND;
							state_q <= S_RESP;
						end
					end
				end
				S_SCAN: begin
					if (i_q == count_q) begin
						// Miss: add appends, the rest report not found
						state_q <= S_RESP;
						if (cmd_q == CMD_ADD) begin
							res_st_q <= ST_DONE;
							res_has_q <= 1'b1;
							res_slot_q <= count_q[IDX_W-1:0];
							count_q <= count_q + 1'b1;
							total_q <= total_q + 1'b1;
						end else begin
							res_st_q <= ST_NOTFOUND;
						end
					end else if (match) begin
						state_q <= S_RESP;
						res_has_q <= 1'b1;
						res_slot_q <= i_q[IDX_W-1:0];
						res_st_q <= (cmd_q == CMD_ADD) ? ST_PRESENT : ST_DONE;
						if (cmd_q == CMD_REMOVE) begin
							n_q <= count_q;
							count_q <= count_q - 1'b1;
							res_shift_q <= 1'b1;
						end
					end else begin
						i_q <= i_inc;
					end
				end
				S_MARK: begin
					if (i_q == count_q) begin
						n_q <= count_q;
						count_q <= count_q - exp_q;
						state_q <= S_REPORT;
					end else begin
						flag_q[i_q[IDX_W-1:0]] <= exp_hit;
						exp_q <= exp_q + CNT_W'(exp_hit);
						i_q <= i_inc;
					end
				end
				S_REPORT: begin
					// Report expired entries from the highest slot down
					if (i_q == '0) begin
						w_q <= '0;
						state_q <= S_COMPACT;
					end else if (!flag_q[i_dec[IDX_W-1:0]]) begin
						i_q <= i_dec;
					end else if (out_free) begin
						out_q.status <= ST_EXPIRED;
						out_q.slot <= i_dec[IDX_W-1:0];
						out_q.sess_id_out <= rid & ID_MASK;
						out_q.ip_out <= rip;
						out_q.port_out <= rport;
						out_q.held_count <= count_q;
						out_q.added_total <= total_q;
						out_q.expired_count <= '0;
						out_q.last <= 1'b0;
						i_q <= i_dec;
					end
				end
				S_COMPACT: begin
					// Pack surviving entries towards slot zero
					if (i_q == n_q) begin
						res_st_q <= ST_DONE;
						res_exp_q <= exp_q;
						state_q <= S_RESP;
					end else begin
						if (!flag_q[i_q[IDX_W-1:0]]) begin
							w_q <= w_q + 1'b1;
						end
						i_q <= i_inc;
					end
				end
				S_RESP: begin
					if (out_free) begin
						out_q.status <= res_st_q;
						out_q.slot <= res_has_q ? res_slot_q : '0;
						out_q.sess_id_out <= res_has_q ? (rid & ID_MASK) : '0;
						out_q.ip_out <= res_has_q ? rip : '0;
						out_q.port_out <= res_has_q ? rport : '0;
						out_q.held_count <= count_q;
						out_q.added_total <= total_q;
						out_q.expired_count <= res_exp_q;
						out_q.last <= 1'b1;
						if (res_shift_q) begin
							i_q <= {1'b0, res_slot_q};
							state_q <= S_SHIFT;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				S_SHIFT: begin
					// Close the gap left by a removed entry
					if (i_inc >= n_q) begin
						state_q <= S_IDLE;
					end else begin
						i_q <= i_inc;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`STA_ASSERT(a_count_bound, count_q <= CNT_W'(MAX_ENTRIES))
	`STA_ASSERT(a_partial_is_expiry, (rsp.valid && !rsp.data.last) |-> (rsp.data.status == ST_EXPIRED))
	`STA_ASSERT_NEXT(a_busy_after_accept, req.valid && req.ready, !req.ready)
endmodule
